// File: hdl/sspq_pkg.sv
package sspq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int KEY_BITS    = 24;
    localparam int ID_BITS     = 8;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_BITS     = ID_BITS + KEY_BITS;
    localparam int IN_WIDTH    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * (1 + ID_BITS + KEY_BITS) + CNT_BITS + 2;
    localparam int OUT_WIDTH   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    // row-wide control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

// File: hdl/sspq_cell.sv
module sspq_cell (
    input  logic                clk,
    input  sspq_pkg::cell_ctrl_t ctrl,
    input  sspq_pkg::entry_t    new_entry,
    input  sspq_pkg::entry_t    left_entry,
    input  logic                left_gt,
    input  sspq_pkg::entry_t    right_entry,
    input  logic                occupied,
    output sspq_pkg::entry_t    entry,
    output logic                gt
);
    import sspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // cell moves right on insert when empty or holding a strictly larger key
    assign gt = !occupied || (entry_reg.key > new_entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && gt)
        begin
            entry_next = left_gt ? left_entry : new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: hdl/stable_sorted_priority_queue_core.sv
// Latency: a result word is valid the cycle after its command word is accepted.
// Throughput: one command word per cycle; every cell of the sorted row compares
// and shifts in the same cycle, and the output register frees as it is taken.
// Reset: entry count and output valid clear; slot contents are not cleared and
// are only ever read below the entry count.
module stable_sorted_priority_queue_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] entity_id, [31:8] key
    input  logic [sspq_pkg::IN_WIDTH-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] popped_valid, [8:1] popped_entity, [32:9] popped_key, [33] head_valid,
    // [41:34] head_entity, [65:42] head_key, [71:66] entry_count, [73:72] error
    output logic [sspq_pkg::OUT_WIDTH-1:0] m_tdata
);
    import sspq_pkg::*;

    logic                  accept_in;
    logic                  full;
    logic                  empty;
    cell_ctrl_t            ctrl;
    entry_t                new_entry;
    entry_t                cells [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gts;

    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  m_tvalid_reg;
    logic [OUT_WIDTH-1:0]  out_reg;

    logic                  popped_valid;
    entry_t                popped;
    entry_t                head_next;
    entry_t                head_out;
    err_t                  err;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept_in = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign new_entry.id  = s_tdata[ID_BITS-1:0];
    assign new_entry.key = s_tdata[IN_BITS-1:ID_BITS];

    assign ctrl.insert = accept_in && (s_tuser == CMD_INSERT) && !full;
    assign ctrl.pop    = accept_in && (s_tuser == CMD_POP) && !empty;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        logic   left_g;
        entry_t right_e;

        if (i == 0)
        begin : g_first
            assign left_e = new_entry;
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cells[i-1];
            assign left_g = gts[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cells[i];
        end
        else
        begin : g_inner
            assign right_e = cells[i+1];
        end

        sspq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .occupied    (count_reg > CNT_BITS'(i)),
            .entry       (cells[i]),
            .gt          (gts[i])
        );
    end

    always_comb
    begin
        count_next   = count_reg;
        popped_valid = 1'b0;
        popped       = '0;
        head_next    = cells[0];
        err          = ERR_NONE;
        unique case (s_tuser)
            CMD_INSERT:
            begin
                if (full)
                begin
                    err = ERR_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (gts[0])
                    begin
                        head_next = new_entry;
                    end
                end
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    err = ERR_EMPTY;
                end
                else
                begin
                    count_next   = count_reg - 1'b1;
                    popped_valid = 1'b1;
                    popped       = cells[0];
                    head_next    = cells[1];
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        head_out = (count_next != '0) ? head_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
            begin
                count_reg <= count_next;
            end
            if (accept_in)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            out_reg <= OUT_WIDTH'({err, count_next, head_out.key, head_out.id,
                                   (count_next != '0), popped.key, popped.id,
                                   popped_valid});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // checks

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink the count");

    a_head_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1 + ID_BITS + KEY_BITS] ==
                      (m_tdata[2*(1+ID_BITS+KEY_BITS) +: CNT_BITS] != '0)))
        else $error("head valid disagrees with entry count");

    a_no_ctrl_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.insert && ctrl.pop))
        else $error("insert and pop in the same cycle");

endmodule
